// ----- rtl/core/ctq_pkg.sv -----
// shared types and codes for the coalescing transfer queue
// no dependencies, used by all files under rtl/core
package ctq_pkg;

    localparam logic       ACT_ENQUEUE = 1'b0;
    localparam logic       ACT_POP     = 1'b1;

    localparam logic [1:0] DEST_CONV   = 2'd0;
    localparam logic [1:0] DEST_DISP   = 2'd1;
    localparam logic [1:0] DEST_NONE   = 2'd3;

    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_SAME_HEAD = 3'd1;
    localparam logic [2:0] ST_MERGED    = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_BAD_DEST  = 3'd5;
    localparam logic [2:0] ST_POPPED    = 3'd6;
    localparam logic [2:0] ST_POP_EMPTY = 3'd7;

    typedef struct packed {
        logic        action;
        logic [1:0]  destination;
        logic [31:0] payload;
        logic        link_busy;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic        start_send;
        logic        head_valid;
        logic [1:0]  head_destination;
        logic [31:0] head_payload;
        logic [3:0]  occupancy;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_step;
        logic       rd_head;
        logic       pop;
        logic       append;
        logic       merge;
        logic       out_load;
        logic [2:0] status;
        logic       start;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic bad_dest;
        logic busy;
        logic hit_head;
        logic hit_merge;
        logic hit_dup;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/ctq_datapath.sv -----
// entry store, pointers, scan compare and result register of the queue
// depends on ctq_pkg
module ctq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ctq_pkg::t_in  i_in_data,
    input  ctq_pkg::t_cmd i_cmd,
    output ctq_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ctq_pkg::t_out o_out_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic [1:0]  dest;
        logic [31:0] payload;
    } t_entry;

    t_entry         r_mem [QUEUE_DEPTH];
    logic           r_vld [QUEUE_DEPTH];

    ctq_pkg::t_in   r_req;
    logic [AW-1:0]  r_rp;
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_scan_addr;
    logic [AW-1:0]  r_scan_cnt;

    t_entry         r_rd_word;
    logic           r_rd_ok;
    logic           r_rd_vld;
    logic           r_rd_first;
    logic [AW-1:0]  r_rd_addr;

    logic           r_out_vld;
    ctq_pkg::t_out  r_out;

    logic [AW-1:0]  occ;
    logic [AW+3:0]  occ_ext;
    logic           empty;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [1:0]     rd_dest;
    logic [31:0]    rd_payload;
    logic           dest_eq;
    logic           pay_eq;
    logic           more;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        if (r_wp >= r_rp) begin
            occ = r_wp - r_rp;
        end else begin
            occ = AW'({1'b0, r_wp} + (AW+1)'(QUEUE_DEPTH) - {1'b0, r_rp});
        end
    end

    assign occ_ext = {4'b0, occ};
    assign empty   = (r_rp == r_wp);
    assign more    = (r_scan_cnt < occ);

    assign rd_addr = i_cmd.rd_head ? r_rp : r_scan_addr;
    // a merge keeps the converter code, so one write port serves both
    assign wr_en   = i_cmd.append | i_cmd.merge;
    assign wr_addr = i_cmd.append ? r_wp : r_rd_addr;

    // never-written slots read as the reset entry
    assign rd_dest    = r_rd_ok ? r_rd_word.dest    : ctq_pkg::DEST_NONE;
    assign rd_payload = r_rd_ok ? r_rd_word.payload : 32'd0;
    assign dest_eq    = (rd_dest == r_req.destination);
    assign pay_eq     = (rd_payload == r_req.payload);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{dest: r_req.destination, payload: r_req.payload};
        end
        r_rd_word <= r_mem[rd_addr];
        r_rd_ok   <= r_vld[rd_addr];
        r_rd_addr <= rd_addr;
        r_rd_first <= (r_scan_cnt == '0);
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
        if (i_cmd.out_load) begin
            r_out.status           <= i_cmd.status;
            r_out.start_send       <= i_cmd.start;
            r_out.head_valid       <= !empty;
            r_out.head_destination <= rd_dest;
            r_out.head_payload     <= rd_payload;
            r_out.occupancy        <= occ_ext[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_scan_addr <= '0;
            r_scan_cnt  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_rp <= next_slot(r_rp);
            end
            if (i_cmd.append) begin
                r_wp <= next_slot(r_wp);
            end
            if (i_cmd.scan_start) begin
                r_scan_addr <= r_rp;
                r_scan_cnt  <= '0;
                r_rd_vld    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= more;
                if (more) begin
                    r_scan_addr <= next_slot(r_scan_addr);
                    r_scan_cnt  <= r_scan_cnt + 1'b1;
                end
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.is_pop    = (r_req.action == ctq_pkg::ACT_POP);
        o_sts.empty     = empty;
        o_sts.full      = (occ == LAST_SLOT);
        o_sts.bad_dest  = r_req.destination[1];
        o_sts.busy      = r_req.link_busy;
        // head and display match on both fields, converters on dest
        o_sts.hit_head  = r_rd_vld && r_rd_first && dest_eq && pay_eq;
        o_sts.hit_merge = r_rd_vld && !r_rd_first && dest_eq
                          && (r_req.destination == ctq_pkg::DEST_CONV);
        o_sts.hit_dup   = r_rd_vld && !r_rd_first && dest_eq && pay_eq
                          && (r_req.destination == ctq_pkg::DEST_DISP);
        o_sts.scan_done = !r_rd_vld && !more;
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (occ != LAST_SLOT))
        else $error("append into a full queue");

    a_merge_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (rd_dest == ctq_pkg::DEST_CONV) && r_rd_ok)
        else $error("merge into a slot that is not a queued converter entry");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !empty ##1 (r_rp != $past(r_rp)))
        else $error("pop on empty queue or read pointer did not move");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten while a beat waits");

endmodule

// ----- rtl/core/ctq_ctrl.sv -----
// sequencer of the queue: decides, scans when needed, commits, then presents the result
// depends on ctq_pkg
module ctq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ctq_pkg::t_sts i_sts,
    output ctq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_APPEND,
        S_HREAD,
        S_RESULT
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_status;
    logic [2:0] n_status;
    logic       r_start;
    logic       n_start;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_start  = r_start;
        o_cmd    = '0;
        o_cmd.status = r_status;
        o_cmd.start  = r_start;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_start    = 1'b0;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_HREAD;
                if (i_sts.is_pop) begin
                    if (i_sts.empty) begin
                        n_status = ctq_pkg::ST_POP_EMPTY;
                    end else begin
                        o_cmd.pop = 1'b1;
                        n_status  = ctq_pkg::ST_POPPED;
                    end
                end else if (i_sts.full) begin
                    n_status = ctq_pkg::ST_FULL;
                end else if (i_sts.bad_dest) begin
                    n_status = ctq_pkg::ST_BAD_DEST;
                end else if (i_sts.empty) begin
                    n_state = S_APPEND;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit_head) begin
                    n_status = ctq_pkg::ST_SAME_HEAD;
                    n_state  = S_HREAD;
                end else if (i_sts.hit_merge) begin
                    o_cmd.merge = 1'b1;
                    n_status    = ctq_pkg::ST_MERGED;
                    n_state     = S_HREAD;
                end else if (i_sts.hit_dup) begin
                    n_status = ctq_pkg::ST_DUPLICATE;
                    n_state  = S_HREAD;
                end else if (i_sts.scan_done) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_status     = ctq_pkg::ST_APPENDED;
                n_start      = !i_sts.busy;
                n_state      = S_HREAD;
            end
            S_HREAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                // keep the head word on the read port while the result waits
                o_cmd.rd_head = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ctq_pkg::ST_APPENDED;
            r_start  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_start  <= n_start;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_start_only_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load && o_cmd.start |-> (o_cmd.status == ctq_pkg::ST_APPENDED))
        else $error("start beat raised without an append");

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.pop, o_cmd.append, o_cmd.merge}) <= 1)
        else $error("more than one queue update in a cycle");

endmodule

// ----- rtl/core/coalescing_transfer_queue.sv -----
// coalescing transfer queue for a converter and a display destination
// top level: joins ctq_ctrl and ctq_datapath, depends on ctq_pkg
//
// usage: a request beat on the input channel either enqueues a transfer
// (action 0) or pops the head that the link has finished (action 1). every
// request gives exactly one result beat with a status code, a start-send
// flag and a view of the head entry and occupancy after the request.
// the ring holds QUEUE_DEPTH-1 requests. a display request equal to a queued
// one is dropped, a converter request rewrites the first queued converter
// entry behind the head, a request equal to the head is dropped.
// timing: one request at a time. pops, full and bad destination pass through
// the decide, head read and result states; an enqueue walks the queued
// entries through the single read port of the entry store, one per cycle,
// appends unless a match ends the walk, then reads the head and presents it.
// reset clears the pointers and marks every slot unwritten, so the head view
// shows destination 3 and payload 0 for slots never written.
// a stalled receiver holds the result in the output register; the next
// request is taken meanwhile and finishes once that beat has left.
module coalescing_transfer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ctq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ctq_pkg::t_out o_out_data
);

    ctq_pkg::t_cmd cmd;
    ctq_pkg::t_sts sts;

    ctq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ctq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
